// ----- hw/rtl/prrs_pkg.sv -----
// Shared types and codes for the priority ring round-robin scheduler.
`default_nettype none
package prrs_pkg;

   localparam logic [1:0] OP_NEXT   = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_PRESENT = 3'd3;
   localparam logic [2:0] ST_ABSENT  = 3'd4;

   typedef struct packed {
      logic [1:0] op;
      logic [3:0] task_id;
      logic [7:0] task_priority;
      logic       current_valid;
      logic [3:0] running_slot;
   } req_type;

   typedef struct packed {
      logic [3:0] chosen_slot;
      logic       next_valid;
      logic [2:0] status;
   } res_type;

endpackage
`default_nettype wire

// ----- hw/rtl/prrs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module prrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/prrs_ctrl.sv -----
// Sequencer for ring operations: get-next, walk, link and unlink with one shared priority compare.
`default_nettype none
module prrs_ctrl
   import prrs_pkg::*;
#(
   parameter int MAX_TASKS     = 16,
   parameter int PRIORITY_BITS = 8,
   localparam int SLOT_W = $clog2(MAX_TASKS),
   localparam int CNT_W  = $clog2(MAX_TASKS + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire req_type                  req,
   input  wire logic                     out_free,
   output logic                          done,
   output res_type                       res,
   output logic                          rd_re,
   output logic [SLOT_W-1:0]             rd_addr,
   input  wire logic [SLOT_W-1:0]        succ_rd,
   input  wire logic [SLOT_W-1:0]        pred_rd,
   input  wire logic [PRIORITY_BITS-1:0] prio_rd,
   output logic                          succ_we,
   output logic [SLOT_W-1:0]             succ_waddr,
   output logic [SLOT_W-1:0]             succ_wdata,
   output logic                          pred_we,
   output logic [SLOT_W-1:0]             pred_waddr,
   output logic [SLOT_W-1:0]             pred_wdata,
   output logic                          prio_we,
   output logic [SLOT_W-1:0]             prio_waddr,
   output logic [PRIORITY_BITS-1:0]      prio_wdata
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_WALK    = 4'd2;
   localparam logic [3:0] S_LINK1   = 4'd3;
   localparam logic [3:0] S_LINK2   = 4'd4;
   localparam logic [3:0] S_LINK3   = 4'd5;
   localparam logic [3:0] S_RM_RD   = 4'd6;
   localparam logic [3:0] S_NEXT_RD = 4'd7;
   localparam logic [3:0] S_FIN     = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic [SLOT_W-1:0]    n_ff, n_in;
   logic [SLOT_W-1:0]    p_ff, p_in;
   logic [SLOT_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [MAX_TASKS-1:0] in_ring_ff, in_ring_in;
   res_type              res_ff, res_in;

   logic                     id_ok, cur_ok, prio_le;
   logic [SLOT_W-1:0]        id_s, cur_s;
   logic [PRIORITY_BITS-1:0] prio_k;

   assign id_ok   = 9'(req.task_id) < 9'(MAX_TASKS);
   assign cur_ok  = 9'(req.running_slot) < 9'(MAX_TASKS);
   assign id_s    = SLOT_W'(req.task_id);
   assign cur_s   = SLOT_W'(req.running_slot);
   assign prio_k  = PRIORITY_BITS'(req.task_priority);
   // shared compare unit
   assign prio_le = prio_rd <= prio_k;

   assign res  = res_ff;
   assign done = (state_ff == S_FIN) && out_free;

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      p_in       = p_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      in_ring_in = in_ring_ff;
      res_in     = res_ff;
      rd_re      = 1'b0;
      rd_addr    = n_ff;
      succ_we    = 1'b0;
      succ_waddr = id_s;
      succ_wdata = id_s;
      pred_we    = 1'b0;
      pred_waddr = id_s;
      pred_wdata = id_s;
      prio_we    = 1'b0;
      prio_waddr = id_s;
      prio_wdata = prio_k;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_in   = '{chosen_slot: 4'd0, next_valid: 1'b0, status: ST_OK};
            state_in = S_FIN;
            case (req.op)
               OP_NEXT: begin
                  if (count_ff == '0) begin
                     res_in.status = ST_EMPTY;
                  end else if (!req.current_valid) begin
                     res_in.chosen_slot = 4'(head_ff);
                     res_in.next_valid  = 1'b1;
                  end else if (!cur_ok || !in_ring_ff[cur_s]) begin
                     res_in.status = ST_ABSENT;
                  end else begin
                     rd_re    = 1'b1;
                     rd_addr  = cur_s;
                     state_in = S_NEXT_RD;
                  end
               end
               OP_ADD: begin
                  if (!id_ok) begin
                     res_in.status = ST_FULL;
                  end else if (in_ring_ff[id_s]) begin
                     res_in.status = ST_PRESENT;
                  end else if (count_ff == CNT_W'(MAX_TASKS)) begin
                     res_in.status = ST_FULL;
                  end else begin
                     prio_we           = 1'b1;
                     in_ring_in[id_s]  = 1'b1;
                     if (count_ff == '0) begin
                        head_in  = id_s;
                        succ_we  = 1'b1;
                        pred_we  = 1'b1;
                        count_in = CNT_W'(1);
                     end else begin
                        rd_re    = 1'b1;
                        rd_addr  = head_ff;
                        n_in     = head_ff;
                        state_in = S_WALK;
                     end
                  end
               end
               OP_REMOVE: begin
                  if (!id_ok || !in_ring_ff[id_s]) begin
                     res_in.status = ST_ABSENT;
                  end else begin
                     in_ring_in[id_s] = 1'b0;
                     if (count_ff == CNT_W'(1)) begin
                        count_in = '0;
                     end else begin
                        rd_re    = 1'b1;
                        rd_addr  = id_s;
                        state_in = S_RM_RD;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_WALK: begin
            if (prio_le) begin
               state_in = S_LINK2;
            end else if (succ_rd == head_ff) begin
               n_in     = head_ff;
               state_in = S_LINK1;
            end else begin
               rd_re   = 1'b1;
               rd_addr = succ_rd;
               n_in    = succ_rd;
            end
         end
         S_LINK1: begin
            rd_re    = 1'b1;
            rd_addr  = n_ff;
            state_in = S_LINK2;
         end
         S_LINK2: begin
            p_in       = pred_rd;
            succ_we    = 1'b1;
            succ_wdata = n_ff;
            pred_we    = 1'b1;
            pred_wdata = pred_rd;
            state_in   = S_LINK3;
         end
         S_LINK3: begin
            succ_we    = 1'b1;
            succ_waddr = p_ff;
            pred_we    = 1'b1;
            pred_waddr = n_ff;
            count_in   = count_ff + CNT_W'(1);
            state_in   = S_FIN;
         end
         S_RM_RD: begin
            succ_we    = 1'b1;
            succ_waddr = pred_rd;
            succ_wdata = succ_rd;
            pred_we    = 1'b1;
            pred_waddr = succ_rd;
            pred_wdata = pred_rd;
            if (head_ff == id_s) begin
               head_in = succ_rd;
            end
            count_in = count_ff - CNT_W'(1);
            state_in = S_FIN;
         end
         S_NEXT_RD: begin
            res_in.chosen_slot = 4'(succ_rd);
            res_in.next_valid  = 1'b1;
            state_in           = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         head_ff    <= '0;
         count_ff   <= '0;
         in_ring_ff <= '0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         in_ring_ff <= in_ring_in;
      end
      n_ff   <= n_in;
      p_ff   <= p_in;
      res_ff <= res_in;
   end

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> $countones(in_ring_ff) == int'(count_ff))
      else $error("ring count disagrees with membership bits");

   a_head_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && count_ff != '0) |-> in_ring_ff[head_ff])
      else $error("head slot not in ring");

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> count_ff != '0)
      else $error("walk on empty ring");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == S_IDLE)
      else $error("transaction started while busy");

endmodule
`default_nettype wire

// ----- hw/rtl/priority_ring_round_robin_scheduler_top.sv -----
// Top level of the priority ring round-robin scheduler: handshakes, link and priority RAMs.
//
// channel  dir  handshake            payload
// req      in   req_valid/req_ready  op, task_id, task_priority, current_valid, running_slot
// rsp      out  rsp_valid/rsp_ready  chosen_slot, next_valid, status
//
// One transaction at a time; req_ready is low from acceptance until the result is registered.
// The insertion walk for add reads one ring entry per cycle through the shared read port of
// the link and priority RAMs.
// A result waiting on rsp_ready holds the sequencer in its final state.
// Synchronous reset empties the ring; link and priority RAMs are not cleared.
`default_nettype none
module priority_ring_round_robin_scheduler_top
   import prrs_pkg::*;
#(
   parameter int MAX_TASKS     = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_op,
   input  wire logic [3:0] req_task_id,
   input  wire logic [7:0] req_task_priority,
   input  wire logic       req_current_valid,
   input  wire logic [3:0] req_running_slot,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [3:0]      rsp_chosen_slot,
   output logic            rsp_next_valid,
   output logic [2:0]      rsp_status
);

   localparam int SLOT_W = $clog2(MAX_TASKS);

   logic    busy_ff, busy_in;
   logic    start_ff, start_in;
   req_type req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_ff;
   logic    accept, out_free, done;
   res_type res;

   logic                     rd_re;
   logic [SLOT_W-1:0]        rd_addr, succ_rd, pred_rd;
   logic [PRIORITY_BITS-1:0] prio_rd;
   logic                     succ_we, pred_we, prio_we;
   logic [SLOT_W-1:0]        succ_waddr, succ_wdata, pred_waddr, pred_wdata, prio_waddr;
   logic [PRIORITY_BITS-1:0] prio_wdata;

   assign req_ready       = !busy_ff;
   assign accept          = req_valid && req_ready;
   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chosen_slot = rsp_ff.chosen_slot;
   assign rsp_next_valid  = rsp_ff.next_valid;
   assign rsp_status      = rsp_ff.status;

   always_comb begin
      start_in     = accept;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         req_ff <= '{op: req_op, task_id: req_task_id, task_priority: req_task_priority,
                     current_valid: req_current_valid, running_slot: req_running_slot};
      end
      if (done) begin
         rsp_ff <= res;
      end
   end

   prrs_ctrl #(
      .MAX_TASKS     (MAX_TASKS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start_ff),
      .req        (req_ff),
      .out_free   (out_free),
      .done       (done),
      .res        (res),
      .rd_re      (rd_re),
      .rd_addr    (rd_addr),
      .succ_rd    (succ_rd),
      .pred_rd    (pred_rd),
      .prio_rd    (prio_rd),
      .succ_we    (succ_we),
      .succ_waddr (succ_waddr),
      .succ_wdata (succ_wdata),
      .pred_we    (pred_we),
      .pred_waddr (pred_waddr),
      .pred_wdata (pred_wdata),
      .prio_we    (prio_we),
      .prio_waddr (prio_waddr),
      .prio_wdata (prio_wdata)
   );

   prrs_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_TASKS)) u_succ_ram (
      .clock (clock),
      .we    (succ_we),
      .waddr (succ_waddr),
      .wdata (succ_wdata),
      .re    (rd_re),
      .raddr (rd_addr),
      .rdata (succ_rd)
   );

   prrs_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_TASKS)) u_pred_ram (
      .clock (clock),
      .we    (pred_we),
      .waddr (pred_waddr),
      .wdata (pred_wdata),
      .re    (rd_re),
      .raddr (rd_addr),
      .rdata (pred_rd)
   );

   prrs_ram #(.WIDTH(PRIORITY_BITS), .DEPTH(MAX_TASKS)) u_prio_ram (
      .clock (clock),
      .we    (prio_we),
      .waddr (prio_waddr),
      .wdata (prio_wdata),
      .re    (rd_re),
      .raddr (rd_addr),
      .rdata (prio_rd)
   );

endmodule
`default_nettype wire
